>>> hdl/frle_pkg.sv
// ----------------------------------------------------------------------------
// frle_pkg
// Shared constants, register indexes and types for the field-pack
// run-length encoder.
// ----------------------------------------------------------------------------
package frle_pkg;

  // data path widths
  localparam int WORD_W     = 64;
  localparam int WIDTH_W    = 7;
  localparam int OFFSET_W   = 9;
  localparam int COUNT_W    = 16;
  localparam int SHIFT_W    = 6;

  // field lanes: one per input field, limited by the field maximum
  localparam int NUM_LANES  = 4;
  localparam int MAX_FIELDS = 4;
  localparam int FIELD_LIMIT = (MAX_FIELDS < NUM_LANES) ? MAX_FIELDS : NUM_LANES;
  localparam int NFIELD_W   = 3;

  // longest run before a pair is closed
  localparam logic [COUNT_W-1:0] MAX_RUN = 16'hFFFF;

  // full mask width
  localparam logic [WIDTH_W-1:0] FULL_WIDTH = 7'd64;

  // output queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_LVL_W = 3;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_FIELDS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_A       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_B       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_C       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_D       = 3'd4;

  localparam logic [NFIELD_W-1:0] ACTIVE_RESET = 3'd1;
  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 7'd8;

  // per-lane setup derived from the configuration registers
  typedef struct packed {
    logic                active;
    logic [WIDTH_W-1:0]  width;
    logic [OFFSET_W-1:0] offset;
  } lane_cfg_t;

  // one (word, count) result
  typedef struct packed {
    logic [WORD_W-1:0]  word;
    logic [COUNT_W-1:0] length;
    logic               final_pair;
  } pair_t;

  // run state seen by the top level
  typedef struct packed {
    logic               run_open;
    logic [COUNT_W-1:0] open_count;
  } rle_status_t;

endpackage

>>> hdl/frle_if.sv
// ----------------------------------------------------------------------------
// frle_in_if / frle_out_if
// Valid/ready channels for entries going in and run pairs coming out.
// ----------------------------------------------------------------------------
interface frle_in_if;
  logic                         valid;
  logic                         ready;
  logic [frle_pkg::WORD_W-1:0]  value_a;
  logic [frle_pkg::WORD_W-1:0]  value_b;
  logic [frle_pkg::WORD_W-1:0]  value_c;
  logic [frle_pkg::WORD_W-1:0]  value_d;
  logic                         end_of_stream;

  modport source (
    output valid, value_a, value_b, value_c, value_d, end_of_stream,
    input  ready
  );
  modport sink (
    input  valid, value_a, value_b, value_c, value_d, end_of_stream,
    output ready
  );
endinterface

interface frle_out_if;
  logic                         valid;
  logic                         ready;
  logic [frle_pkg::WORD_W-1:0]  run_word;
  logic [frle_pkg::COUNT_W-1:0] run_length;
  logic                         final_pair;

  modport source (
    output valid, run_word, run_length, final_pair,
    input  ready
  );
  modport sink (
    input  valid, run_word, run_length, final_pair,
    output ready
  );
endinterface

>>> hdl/frle_lane.sv
// ----------------------------------------------------------------------------
// frle_lane
// One field lane: masks a value to its width and shifts it to its place
// in the packed word, registered.
// ----------------------------------------------------------------------------
module frle_lane (
  input  logic                        clk,
  input  logic                        load,
  input  logic [frle_pkg::WORD_W-1:0] value,
  input  frle_pkg::lane_cfg_t         lane_cfg,
  output logic [frle_pkg::WORD_W-1:0] lane_word
);
  import frle_pkg::*;

  logic [WORD_W-1:0] mask;
  logic [WORD_W-1:0] placed;
  logic [WORD_W-1:0] lane_word_r;

  // width mask, full at 64
  always_comb begin
    if (lane_cfg.width >= FULL_WIDTH) begin
      mask = '1;
    end else begin
      mask = ~({WORD_W{1'b1}} << lane_cfg.width[SHIFT_W-1:0]);
    end
  end

  // fields placed at or above the top of the word are dropped
  always_comb begin
    if (lane_cfg.active && (lane_cfg.offset < OFFSET_W'(WORD_W))) begin
      placed = (value & mask) << lane_cfg.offset[SHIFT_W-1:0];
    end else begin
      placed = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lane_word_r <= placed;
    end
  end

  assign lane_word = lane_word_r;

endmodule

>>> hdl/frle_rle.sv
// ----------------------------------------------------------------------------
// frle_rle
// Merges the lane words into the packed word and keeps the open run;
// closes and flushes pairs.
// ----------------------------------------------------------------------------
module frle_rle (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        take,
  input  logic [frle_pkg::WORD_W-1:0] lane_words [frle_pkg::NUM_LANES],
  input  logic                        end_of_stream,
  output frle_pkg::pair_t             pair0,
  output logic                        push0,
  output frle_pkg::pair_t             pair1,
  output logic                        push1,
  output frle_pkg::rle_status_t       status
);
  import frle_pkg::*;

  logic [WORD_W-1:0]  packed_word;
  logic [WORD_W-1:0]  open_word_r, open_word_nxt;
  logic [COUNT_W-1:0] open_count_r, open_count_nxt;
  logic               run_open_r, run_open_nxt;
  logic [WORD_W-1:0]  cont_word;
  logic [COUNT_W-1:0] cont_count;

  // merge the lanes
  always_comb begin
    packed_word = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      packed_word = packed_word | lane_words[i];
    end
  end

  // extend, start or close the run, then flush on end of stream
  always_comb begin
    cont_word  = open_word_r;
    cont_count = open_count_r;
    push0      = 1'b0;
    pair0      = '{word: open_word_r, length: open_count_r, final_pair: 1'b0};
    if (!run_open_r) begin
      cont_word  = packed_word;
      cont_count = COUNT_W'(1);
    end else if ((packed_word == open_word_r) && (open_count_r < MAX_RUN)) begin
      cont_count = open_count_r + COUNT_W'(1);
    end else begin
      push0      = take;
      cont_word  = packed_word;
      cont_count = COUNT_W'(1);
    end

    pair1 = '{word: cont_word, length: cont_count, final_pair: 1'b1};
    push1 = take && end_of_stream;

    open_word_nxt  = open_word_r;
    open_count_nxt = open_count_r;
    run_open_nxt   = run_open_r;
    if (take) begin
      if (end_of_stream) begin
        open_word_nxt  = '0;
        open_count_nxt = '0;
        run_open_nxt   = 1'b0;
      end else begin
        open_word_nxt  = cont_word;
        open_count_nxt = cont_count;
        run_open_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_word_r  <= '0;
      open_count_r <= '0;
      run_open_r   <= 1'b0;
    end else begin
      open_word_r  <= open_word_nxt;
      open_count_r <= open_count_nxt;
      run_open_r   <= run_open_nxt;
    end
  end

  assign status = '{run_open: run_open_r, open_count: open_count_r};

endmodule

>>> hdl/frle_out_fifo.sv
// ----------------------------------------------------------------------------
// frle_out_fifo
// Small result queue; takes up to two pairs per cycle and hands out one.
// ----------------------------------------------------------------------------
module frle_out_fifo (
  input  logic                            clk,
  input  logic                            rst_n,
  input  frle_pkg::pair_t                 pair0,
  input  logic                            push0,
  input  frle_pkg::pair_t                 pair1,
  input  logic                            push1,
  input  logic                            pop,
  output frle_pkg::pair_t                 head,
  output logic [frle_pkg::FIFO_LVL_W-1:0] level
);
  import frle_pkg::*;

  pair_t                 mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_r, wr_nxt;
  logic [FIFO_PTR_W-1:0] rd_r, rd_nxt;
  logic [FIFO_LVL_W-1:0] level_r, level_nxt;
  logic [FIFO_LVL_W-1:0] n_push;

  // pointer and level update
  always_comb begin
    n_push    = FIFO_LVL_W'(push0) + FIFO_LVL_W'(push1);
    wr_nxt    = wr_r + n_push[FIFO_PTR_W-1:0];
    rd_nxt    = pop ? rd_r + FIFO_PTR_W'(1) : rd_r;
    level_nxt = level_r + n_push - FIFO_LVL_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      level_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      level_r <= level_nxt;
    end
  end

  // storage: the closed pair goes ahead of the flushed one
  always_ff @(posedge clk) begin
    if (push0) begin
      mem[wr_r] <= pair0;
      if (push1) begin
        mem[wr_r + FIFO_PTR_W'(1)] <= pair1;
      end
    end else if (push1) begin
      mem[wr_r] <= pair1;
    end
  end

  assign head  = mem[rd_r];
  assign level = level_r;

endmodule

>>> hdl/field_pack_rle_encoder.sv
// ----------------------------------------------------------------------------
// field_pack_rle_encoder
// Packs up to four masked fields into a 64-bit word in parallel lanes and
// run-length encodes the packed words into (word, count) pairs.
//
//   port    direction  carries
//   in_if   sink       value_a..value_d, end_of_stream per entry
//   out_if  source     run_word, run_length, final_pair per pair
//   cfg_*   write      active_fields, width_a..width_d by index
//
// One entry is taken per cycle unless the input is stalled as below; from
// input transfer to the pair at the output it passes the lane register, then
// the run stage into the queue. The run stage takes an entry only while the
// four-deep result queue has room for two pairs, so with the output stalled
// the queue fills to at most four pairs, the entry in the lane register then
// waits and the input stalls behind it. An end-of-stream entry that also
// closes a run gives two pairs. Reset is synchronous, active low, and clears
// the run state, the queue and the configuration registers to their defaults.
// ----------------------------------------------------------------------------
module field_pack_rle_encoder (
  input  logic                            clk,
  input  logic                            rst_n,
  frle_in_if.sink                         in_if,
  frle_out_if.source                      out_if,
  input  logic                            cfg_wr_en,
  input  logic [frle_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [frle_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
  import frle_pkg::*;

  logic [NFIELD_W-1:0] active_fields_r;
  logic [WIDTH_W-1:0]  width_r [NUM_LANES];
  logic [NFIELD_W-1:0] n_fields;
  lane_cfg_t           lane_cfg [NUM_LANES];
  logic [WORD_W-1:0]   lane_value [NUM_LANES];
  logic [WORD_W-1:0]   lane_words [NUM_LANES];
  logic                s1_valid_r, s1_valid_nxt;
  logic                s1_eos_r;
  logic                in_xfer;
  logic                take;
  pair_t               pair0, pair1, head;
  logic                push0, push1;
  logic                pop;
  logic [FIFO_LVL_W-1:0] fifo_level;
  rle_status_t         rle_status;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_fields_r <= ACTIVE_RESET;
      for (int i = 0; i < NUM_LANES; i++) begin
        width_r[i] <= WIDTH_RESET;
      end
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ACTIVE_FIELDS: active_fields_r <= cfg_wr_data[NFIELD_W-1:0];
        REG_WIDTH_A:       width_r[0] <= cfg_wr_data;
        REG_WIDTH_B:       width_r[1] <= cfg_wr_data;
        REG_WIDTH_C:       width_r[2] <= cfg_wr_data;
        REG_WIDTH_D:       width_r[3] <= cfg_wr_data;
        default:           ;
      endcase
    end
  end

  // field count, clamped to one..limit
  always_comb begin
    if (active_fields_r == '0) begin
      n_fields = NFIELD_W'(1);
    end else if (active_fields_r > NFIELD_W'(FIELD_LIMIT)) begin
      n_fields = NFIELD_W'(FIELD_LIMIT);
    end else begin
      n_fields = active_fields_r;
    end
  end

  // lane setup: saturated width and bit offset, last active field at bit 0
  always_comb begin
    logic [OFFSET_W-1:0] pos;
    pos = '0;
    for (int i = NUM_LANES - 1; i >= 0; i--) begin
      lane_cfg[i].active = (NFIELD_W'(i) < n_fields);
      lane_cfg[i].width  = (width_r[i] > FULL_WIDTH) ? FULL_WIDTH : width_r[i];
      lane_cfg[i].offset = pos;
      if (lane_cfg[i].active) begin
        pos = pos + OFFSET_W'(lane_cfg[i].width);
      end
    end
  end

  assign lane_value[0] = in_if.value_a;
  assign lane_value[1] = in_if.value_b;
  assign lane_value[2] = in_if.value_c;
  assign lane_value[3] = in_if.value_d;

  // input handshake and lane stage valid
  assign take         = s1_valid_r && (fifo_level <= FIFO_LVL_W'(FIFO_DEPTH - 2));
  assign in_if.ready  = !s1_valid_r || take;
  assign in_xfer      = in_if.valid && in_if.ready;
  assign s1_valid_nxt = in_xfer ? 1'b1 : (take ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_eos_r <= in_if.end_of_stream;
    end
  end

  // field lanes
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    frle_lane u_lane (
      .clk       (clk),
      .load      (in_xfer),
      .value     (lane_value[g]),
      .lane_cfg  (lane_cfg[g]),
      .lane_word (lane_words[g])
    );
  end

  // merge and run stage
  frle_rle u_rle (
    .clk           (clk),
    .rst_n         (rst_n),
    .take          (take),
    .lane_words    (lane_words),
    .end_of_stream (s1_eos_r),
    .pair0         (pair0),
    .push0         (push0),
    .pair1         (pair1),
    .push1         (push1),
    .status        (rle_status)
  );

  // result queue
  assign pop = out_if.valid && out_if.ready;

  frle_out_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .pair0 (pair0),
    .push0 (push0),
    .pair1 (pair1),
    .push1 (push1),
    .pop   (pop),
    .head  (head),
    .level (fifo_level)
  );

  assign out_if.valid      = (fifo_level != '0);
  assign out_if.run_word   = head.word;
  assign out_if.run_length = head.length;
  assign out_if.final_pair = head.final_pair;

  // checks
  assert property (@(posedge clk) disable iff (!rst_n)
    fifo_level <= FIFO_LVL_W'(FIFO_DEPTH))
    else $error("result queue overfilled");

  assert property (@(posedge clk) disable iff (!rst_n)
    (push0 || push1) |-> take)
    else $error("pair pushed without an entry taken");

  assert property (@(posedge clk) disable iff (!rst_n)
    rle_status.run_open |-> (rle_status.open_count != '0))
    else $error("open run with zero count");

  assert property (@(posedge clk) disable iff (!rst_n)
    (take && s1_eos_r) |=> !rle_status.run_open)
    else $error("run still open after end of stream");

endmodule
